// ----- rtl/core/zlc_pkg.sv -----
// Types, constants and threshold table shared by the zone loop classifier.
`default_nettype none
package zlc_pkg;

	localparam int SampleW      = 10;
	localparam int ZoneW        = 5;
	localparam int LevelW       = 4;
	localparam int StatusW      = 3;
	localparam int SupplyLevels = 9;

	typedef logic [SampleW-1:0] sample_t;
	typedef logic [LevelW-1:0]  level_t;
	typedef logic [StatusW-1:0] status_t;
	typedef logic [ZoneW-1:0]   zone_t;

	localparam sample_t MainsValue = 10'd250;

	localparam logic OpSupply = 1'b0;
	localparam logic OpZone   = 1'b1;

	localparam status_t StNone   = 3'd0;
	localparam status_t StNormal = 3'd1;
	localparam status_t StShort  = 3'd2;
	localparam status_t StOpen   = 3'd3;
	localparam status_t StFire   = 3'd4;

	typedef struct packed {
		sample_t sup_lo;
		sample_t sup_hi;
		sample_t sh_lo;
		sample_t sh_hi;
		sample_t op_lo;
		sample_t op_hi;
		sample_t fi_lo;
		sample_t fi_hi;
	} thr_row_t;

	typedef struct packed {
		logic    opcode;
		logic    on_battery;
		sample_t battery_sample;
		zone_t   zone_number;
		sample_t zone_sample;
		logic    zone_isolated;
	} req_t;

	typedef struct packed {
		level_t  level_index;
		zone_t   zone_reported;
		status_t zone_status;
		logic    any_fire;
	} rsp_t;

	function automatic thr_row_t thr_row(input level_t row);
		thr_row_t t;
		unique case (row)
			4'd0:    t = '{10'd686, 10'd800, 10'd0, 10'd100, 10'd950, 10'd1023, 10'd260, 10'd300};
			4'd1:    t = '{10'd656, 10'd685, 10'd0, 10'd100, 10'd900, 10'd1000, 10'd250, 10'd285};
			4'd2:    t = '{10'd626, 10'd655, 10'd0, 10'd100, 10'd850, 10'd950,  10'd240, 10'd270};
			4'd3:    t = '{10'd606, 10'd625, 10'd0, 10'd100, 10'd800, 10'd950,  10'd225, 10'd280};
			4'd4:    t = '{10'd576, 10'd605, 10'd0, 10'd100, 10'd800, 10'd900,  10'd225, 10'd270};
			4'd5:    t = '{10'd546, 10'd575, 10'd0, 10'd100, 10'd750, 10'd850,  10'd210, 10'd245};
			4'd6:    t = '{10'd526, 10'd545, 10'd0, 10'd100, 10'd700, 10'd810,  10'd205, 10'd225};
			4'd7:    t = '{10'd500, 10'd525, 10'd0, 10'd100, 10'd650, 10'd730,  10'd150, 10'd205};
			4'd8:    t = '{10'd200, 10'd300, 10'd0, 10'd100, 10'd860, 10'd1023, 10'd240, 10'd300};
			default: t = '0;
		endcase
		return t;
	endfunction

	// Ranges are open at the low end and closed at the high end.
	function automatic logic in_range(input sample_t v, input sample_t lo, input sample_t hi);
		return (v > lo) && (v <= hi);
	endfunction

endpackage
`default_nettype wire

// ----- rtl/core/zlc_stream_if.sv -----
// Valid/ready stream interface carrying one request or result payload.
`default_nettype none
interface zlc_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/zlc_supply_sel.sv -----
// Supply threshold row selection from the battery or mains value.
`default_nettype none
module zlc_supply_sel (
	input  wire logic            on_battery,
	input  wire zlc_pkg::sample_t battery_sample,
	input  wire zlc_pkg::level_t  level_cur,
	output      zlc_pkg::level_t  level_next
);
	import zlc_pkg::*;

	sample_t  sel_value;
	thr_row_t row;

	assign sel_value = on_battery ? battery_sample : MainsValue;

	// Scanning from the last row down leaves the first matching row in place.
	always_comb begin
		level_next = level_cur;
		row        = '0;
		for (int r = SupplyLevels - 1; r >= 0; r--) begin
			row = thr_row(LevelW'(r));
			if (in_range(sel_value, row.sup_lo, row.sup_hi)) begin
				level_next = LevelW'(r);
			end
		end
	end
endmodule
`default_nettype wire

// ----- rtl/core/zlc_zone_class.sv -----
// Loop sample classification against the selected threshold row.
`default_nettype none
module zlc_zone_class (
	input  wire zlc_pkg::level_t  level,
	input  wire zlc_pkg::sample_t zone_sample,
	output      zlc_pkg::status_t status
);
	import zlc_pkg::*;

	thr_row_t row;

	assign row = thr_row(level);

	always_comb begin
		priority if (in_range(zone_sample, row.sh_lo, row.sh_hi)) begin
			status = StShort;
		end else if (in_range(zone_sample, row.op_lo, row.op_hi)) begin
			status = StOpen;
		end else if (in_range(zone_sample, row.fi_lo, row.fi_hi)) begin
			status = StFire;
		end else begin
			status = StNormal;
		end
	end
endmodule
`default_nettype wire

// ----- rtl/core/zlc_zone_store.sv -----
// Per-zone status memory with valid bits, write bypass and fire flags.
`default_nettype none
module zlc_zone_store #(
	parameter int ZONES = 32
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 rd_en,
	input  wire logic [$clog2(ZONES)-1:0] rd_idx,
	input  wire logic                 wr_en,
	input  wire logic [$clog2(ZONES)-1:0] wr_idx,
	input  wire zlc_pkg::status_t     wr_status,
	output      zlc_pkg::status_t     stored,
	output      logic                 fire_any_next
);
	import zlc_pkg::*;

	status_t          mem [ZONES];
	logic [ZONES-1:0] valid_q;
	logic [ZONES-1:0] fire_q;
	logic [ZONES-1:0] fire_next;
	status_t          rd_data_s1;
	logic             rd_valid_s1;
	logic             byp_s1;
	status_t          byp_status_s1;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_idx] <= wr_status;
		end
		if (rd_en) begin
			rd_data_s1    <= mem[rd_idx];
			byp_status_s1 <= wr_status;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			fire_q      <= '0;
			rd_valid_s1 <= 1'b0;
			byp_s1      <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_idx] <= 1'b1;
			end
			fire_q <= fire_next;
			if (rd_en) begin
				rd_valid_s1 <= valid_q[rd_idx];
				byp_s1      <= wr_en && (wr_idx == rd_idx);
			end
		end
	end

	always_comb begin
		fire_next = fire_q;
		if (wr_en) begin
			fire_next[wr_idx] = (wr_status == StFire);
		end
	end

	// Zone zero is never written, so its flag stays clear.
	assign fire_any_next = |fire_next;

	assign stored = byp_s1 ? byp_status_s1 : (rd_valid_s1 ? rd_data_s1 : StNone);
endmodule
`default_nettype wire

// ----- rtl/core/zone_loop_classifier.sv -----
// Top level of the fire alarm zone loop classifier.
// Requests arrive on the req channel and results leave on the rsp channel,
// both valid/ready streams; a request is taken when valid and ready are high.
// A supply request selects a threshold row from the battery sample, or from
// the fixed mains value when on_battery is low. A zone request classifies the
// loop sample of a non-isolated zone from one upward against that row and
// stores the status. Every request gives exactly one result.
// A request is registered on acceptance, together with the registered read
// of its zone's stored status, and its result is then registered in the
// result register when it advances, which waits while rsp.ready is low.
// One request is accepted every cycle unless rsp.ready stalls; the threshold
// compares and the status memory port each handle one request per cycle.
// Reset clears the selected row to zero and marks every zone unclassified
// through per-zone valid bits, so no clearing pass is needed.
// When the receiver holds rsp.ready low the result register keeps its value,
// one further request waits in the input register, and req.ready then drops.
`default_nettype none
module zone_loop_classifier #(
	parameter int ZONES = 32
) (
	input wire logic  clk,
	input wire logic  arst_n,
	zlc_stream_if.sink   req,
	zlc_stream_if.source rsp
);
	import zlc_pkg::*;

	localparam int IdxW = $clog2(ZONES);

	logic            vld_s1;
	req_t            req_s1;
	logic            rsp_vld_q;
	rsp_t            rsp_q;
	level_t          supply_level_q;
	level_t          level_next;
	status_t         class_status;
	status_t         stored;
	logic            fire_any_next;
	logic            advance;
	logic            accept;
	logic            zone_ok;
	logic            do_class;
	logic            wr_en;
	logic [IdxW-1:0] rd_idx;
	logic [IdxW-1:0] wr_idx;
	rsp_t            rsp_next;
	req_t            req_in;

	assign req_in    = req.data;
	assign advance   = vld_s1 && (!rsp_vld_q || rsp.ready);
	assign req.ready = !vld_s1 || advance;
	assign accept    = req.valid && req.ready;

	assign rd_idx   = IdxW'(req_in.zone_number);
	assign wr_idx   = IdxW'(req_s1.zone_number);
	assign zone_ok  = int'(req_s1.zone_number) < ZONES;
	assign do_class = (req_s1.opcode == OpZone) && zone_ok
		&& (req_s1.zone_number != '0) && !req_s1.zone_isolated;
	assign wr_en    = advance && do_class;

	zlc_supply_sel u_supply_sel (
		.on_battery     (req_s1.on_battery),
		.battery_sample (req_s1.battery_sample),
		.level_cur      (supply_level_q),
		.level_next     (level_next)
	);

	zlc_zone_class u_zone_class (
		.level       (supply_level_q),
		.zone_sample (req_s1.zone_sample),
		.status      (class_status)
	);

	zlc_zone_store #(
		.ZONES (ZONES)
	) u_zone_store (
		.clk           (clk),
		.arst_n        (arst_n),
		.rd_en         (accept),
		.rd_idx        (rd_idx),
		.wr_en         (wr_en),
		.wr_idx        (wr_idx),
		.wr_status     (class_status),
		.stored        (stored),
		.fire_any_next (fire_any_next)
	);

	always_comb begin
		rsp_next          = '0;
		rsp_next.any_fire = fire_any_next;
		if (req_s1.opcode == OpSupply) begin
			rsp_next.level_index = level_next;
		end else begin
			rsp_next.level_index   = supply_level_q;
			rsp_next.zone_reported = req_s1.zone_number;
			if (do_class) begin
				rsp_next.zone_status = class_status;
			end else if (zone_ok) begin
				rsp_next.zone_status = stored;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1         <= 1'b0;
			rsp_vld_q      <= 1'b0;
			supply_level_q <= '0;
		end else begin
			if (accept) begin
				vld_s1 <= 1'b1;
			end else if (advance) begin
				vld_s1 <= 1'b0;
			end
			if (advance) begin
				rsp_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_vld_q <= 1'b0;
			end
			if (advance && (req_s1.opcode == OpSupply)) begin
				supply_level_q <= level_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1 <= req_in;
		end
		if (advance) begin
			rsp_q <= rsp_next;
		end
	end

	assign rsp.valid = rsp_vld_q;
	assign rsp.data  = rsp_q;
endmodule
`default_nettype wire
